>>> design/skyline_glyph_atlas_packer_macros.svh
// Assertion macros used by the checker file of the atlas packer.
`ifndef SKYLINE_GLYPH_ATLAS_PACKER_MACROS_SVH
`define SKYLINE_GLYPH_ATLAS_PACKER_MACROS_SVH

// Check a property while out of reset.
`define SGAP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgap: assertion failed");

// Check a property at every edge, reset included.
`define SGAP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sgap: reset assertion failed");

`endif

>>> design/sgap_pkg.sv
// Shared constants, codes and types of the skyline glyph atlas packer.
package sgap_pkg;

  localparam int MAX_ATLAS_WIDTH = 1024;
  localparam int GLYPHS_PER_ROW  = 16;

  localparam int COL_W = $clog2(MAX_ATLAS_WIDTH);
  localparam int PX_W  = 10;
  localparam int TOP_W = 16;
  localparam int HGT_W = 7;
  localparam int SUM_W = ((COL_W > PX_W) ? COL_W : PX_W) + 3;

  localparam logic [TOP_W-1:0] HEIGHT_LIMIT = 16'd65534;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 7'd16;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_WIDE = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_PLACE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] addr;
    logic [TOP_W-1:0] wdata;
  } mem_req_t;

endpackage

>>> design/sgap_col_ram.sv
// Single-port skyline column memory with registered read data.
module sgap_col_ram
  import sgap_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [TOP_W-1:0] rdata
);

  logic [TOP_W-1:0] mem [MAX_ATLAS_WIDTH];
  logic [TOP_W-1:0] rdata_r;

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/sgap_ctrl.sv
// Sequencer and shared max/compare datapath of the atlas packer.
module sgap_ctrl
  import sgap_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_operation,
  input  logic [PX_W-1:0]  in_glyph_width,
  input  logic [PX_W-1:0]  in_glyph_rows,
  input  logic             cfg_we,
  input  logic [HGT_W-1:0] cfg_glyph_height_px,
  output logic             busy,
  output mem_req_t         mem_req,
  input  logic [TOP_W-1:0] mem_rdata,
  output logic             out_strobe,
  output logic [PX_W-1:0]  out_place_x,
  output logic [TOP_W-1:0] out_place_y,
  output logic [TOP_W-1:0] out_atlas_height,
  output logic [1:0]       out_status
);

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] idx_r, idx_nxt;
  logic [COL_W-1:0] base_r, base_nxt;
  logic [PX_W-1:0]  wid_r, wid_nxt;
  logic [PX_W-1:0]  rows_r, rows_nxt;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic [TOP_W-1:0] bottom_r, bottom_nxt;
  logic [PX_W-1:0]  cursor_r, cursor_nxt;
  logic [TOP_W-1:0] tallest_r, tallest_nxt;
  logic [HGT_W-1:0] height_r;
  logic             clr_r, clr_nxt;
  logic             rd_vld_r;

  logic             strobe_r, strobe_nxt;
  logic [PX_W-1:0]  x_r, x_nxt;
  logic [TOP_W-1:0] y_r, y_nxt;
  logic [TOP_W-1:0] h_r, h_nxt;
  status_t          stat_r, stat_nxt;

  logic [SUM_W-1:0] aw_prod, aw, w1;
  logic             too_wide, wrap;
  logic [TOP_W-1:0] fold_max;
  logic [TOP_W:0]   bottom_sum;
  logic [TOP_W-1:0] tallest_upd;
  logic [SUM_W-1:0] cursor_sum;

  // Atlas width and the fit checks of the incoming glyph
  always_comb begin
    aw_prod  = SUM_W'(height_r) * SUM_W'(GLYPHS_PER_ROW);
    aw       = (aw_prod > SUM_W'(MAX_ATLAS_WIDTH)) ? SUM_W'(MAX_ATLAS_WIDTH) : aw_prod;
    w1       = SUM_W'(in_glyph_width) + SUM_W'(1);
    too_wide = (w1 >= aw);
    wrap     = ((SUM_W'(cursor_r) + w1) >= aw);
  end

  // Shared unit: running max, overflow sum and final extents
  always_comb begin
    fold_max    = (rd_vld_r && (mem_rdata > top_r)) ? mem_rdata : top_r;
    bottom_sum  = {1'b0, top_r} + (TOP_W+1)'(1) + (TOP_W+1)'(rows_r);
    tallest_upd = (bottom_r > tallest_r) ? bottom_r : tallest_r;
    cursor_sum  = SUM_W'(base_r) + SUM_W'(wid_r) + SUM_W'(1);
  end

  // Next state, memory request and result beat
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    base_nxt    = base_r;
    wid_nxt     = wid_r;
    rows_nxt    = rows_r;
    top_nxt     = top_r;
    bottom_nxt  = bottom_r;
    cursor_nxt  = cursor_r;
    tallest_nxt = tallest_r;
    clr_nxt     = clr_r;
    strobe_nxt  = 1'b0;
    x_nxt       = x_r;
    y_nxt       = y_r;
    h_nxt       = h_r;
    stat_nxt    = stat_r;
    mem_req     = '{we: 1'b0, addr: base_r + idx_r, wdata: bottom_r};

    unique case (state_r)
      S_SWEEP: begin
        mem_req = '{we: 1'b1, addr: idx_r, wdata: '0};
        idx_nxt = idx_r + COL_W'(1);
        if (idx_r == COL_W'(MAX_ATLAS_WIDTH - 1)) begin
          state_nxt = S_IDLE;
          clr_nxt   = 1'b0;
          if (clr_r) begin
            strobe_nxt = 1'b1;
            x_nxt      = '0;
            y_nxt      = '0;
            h_nxt      = TOP_W'(1);
            stat_nxt   = STAT_OK;
          end
        end
      end

      S_IDLE: begin
        if (start) begin
          if (op_t'(in_operation) == OP_CLEAR) begin
            cursor_nxt  = '0;
            tallest_nxt = '0;
            idx_nxt     = '0;
            clr_nxt     = 1'b1;
            state_nxt   = S_SWEEP;
          end else if (too_wide) begin
            strobe_nxt = 1'b1;
            x_nxt      = '0;
            y_nxt      = '0;
            h_nxt      = tallest_r + TOP_W'(1);
            stat_nxt   = STAT_WIDE;
          end else begin
            base_nxt  = wrap ? '0 : COL_W'(cursor_r);
            wid_nxt   = in_glyph_width;
            rows_nxt  = in_glyph_rows;
            idx_nxt   = '0;
            top_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      // Issue one read per column, fold the previous one
      S_SCAN: begin
        top_nxt = fold_max;
        idx_nxt = idx_r + COL_W'(1);
        if (idx_r == COL_W'(wid_r)) begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        top_nxt   = fold_max;
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (bottom_sum > {1'b0, HEIGHT_LIMIT}) begin
          strobe_nxt = 1'b1;
          x_nxt      = '0;
          y_nxt      = '0;
          h_nxt      = tallest_r + TOP_W'(1);
          stat_nxt   = STAT_OVF;
          state_nxt  = S_IDLE;
        end else begin
          bottom_nxt = bottom_sum[TOP_W-1:0];
          idx_nxt    = '0;
          state_nxt  = S_WRITE;
        end
      end

      // Raise one column per cycle
      S_WRITE: begin
        mem_req = '{we: 1'b1, addr: base_r + idx_r, wdata: bottom_r};
        idx_nxt = idx_r + COL_W'(1);
        if (idx_r == COL_W'(wid_r)) begin
          cursor_nxt  = cursor_sum[PX_W-1:0];
          tallest_nxt = tallest_upd;
          strobe_nxt  = 1'b1;
          x_nxt       = PX_W'(base_r) + PX_W'(1);
          y_nxt       = top_r + TOP_W'(1);
          h_nxt       = tallest_upd + TOP_W'(1);
          stat_nxt    = STAT_OK;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_SWEEP;
      idx_r     <= '0;
      cursor_r  <= '0;
      tallest_r <= '0;
      clr_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      strobe_r  <= 1'b0;
      height_r  <= HEIGHT_RESET;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cursor_r  <= cursor_nxt;
      tallest_r <= tallest_nxt;
      clr_r     <= clr_nxt;
      rd_vld_r  <= (state_r == S_SCAN);
      strobe_r  <= strobe_nxt;
      if (cfg_we) begin
        height_r <= cfg_glyph_height_px;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    wid_r    <= wid_nxt;
    rows_r   <= rows_nxt;
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    h_r      <= h_nxt;
    stat_r   <= stat_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = strobe_r;
  assign out_place_x      = x_r;
  assign out_place_y      = y_r;
  assign out_atlas_height = h_r;
  assign out_status       = stat_r;

endmodule

>>> design/skyline_glyph_atlas_packer.sv
// Top level of the skyline glyph atlas packer.
//
// Usage: raise start with in_operation, in_glyph_width and in_glyph_rows;
// the beat is taken at a clock edge where start is high and busy is low.
// Operation place puts one glyph on the skyline; operation clear zeroes it.
// Each beat gives exactly one result, shown for one cycle with out_strobe
// high: out_place_x, out_place_y, out_atlas_height and out_status.
// The receiver cannot stall; results must be taken in the strobe cycle.
// A placed glyph of width w makes one skyline read pass and one write pass
// over w+1 columns through the single memory port before its result. A glyph
// that would overflow the 16-bit height answers after the read pass alone.
// A glyph too wide for the atlas answers in the cycle after it is taken.
// A clear sweeps all 1024 columns, one per cycle, before it answers. busy
// drops in the result cycle, so a new beat can be taken at the edge that
// ends it. After reset the same sweep runs first with busy high, and no
// result is given for it. cfg_we writes cfg_glyph_height_px at once; write
// it only while the block is idle.
module skyline_glyph_atlas_packer
  import sgap_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_operation,
  input  logic [PX_W-1:0]  in_glyph_width,
  input  logic [PX_W-1:0]  in_glyph_rows,
  input  logic             cfg_we,
  input  logic [HGT_W-1:0] cfg_glyph_height_px,
  output logic             out_strobe,
  output logic [PX_W-1:0]  out_place_x,
  output logic [TOP_W-1:0] out_place_y,
  output logic [TOP_W-1:0] out_atlas_height,
  output logic [1:0]       out_status
);

  mem_req_t         mem_req;
  logic [TOP_W-1:0] mem_rdata;

  sgap_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_operation        (in_operation),
    .in_glyph_width      (in_glyph_width),
    .in_glyph_rows       (in_glyph_rows),
    .cfg_we              (cfg_we),
    .cfg_glyph_height_px (cfg_glyph_height_px),
    .busy                (busy),
    .mem_req             (mem_req),
    .mem_rdata           (mem_rdata),
    .out_strobe          (out_strobe),
    .out_place_x         (out_place_x),
    .out_place_y         (out_place_y),
    .out_atlas_height    (out_atlas_height),
    .out_status          (out_status)
  );

  sgap_col_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

>>> design/sgap_checker.sv
// Port-level checker of the atlas packer and its bind.
`include "skyline_glyph_atlas_packer_macros.svh"

module sgap_checker
  import sgap_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_operation,
  input logic             out_strobe,
  input logic [PX_W-1:0]  out_place_x,
  input logic [TOP_W-1:0] out_place_y,
  input logic [TOP_W-1:0] out_atlas_height,
  input logic [1:0]       out_status
);

  logic clear_beat;
  logic reject_beat;
  logic placed_beat;

  // Decode the beats the assertions look at
  assign clear_beat  = start && !busy && (in_operation == OP_CLEAR);
  assign reject_beat = out_strobe && ((out_status == STAT_WIDE) || (out_status == STAT_OVF));
  assign placed_beat = out_strobe && (out_status == STAT_OK);

  // Reset starts the column sweep and drops any result
  `SGAP_ASSERT_ALWAYS(a_reset_sweep, clk, !rst_n |=> (busy && !out_strobe))

  // A clear beat starts a sweep
  `SGAP_ASSERT(a_clear_busy, clk, rst_n, clear_beat |=> busy)

  // A rejected glyph carries no position
  `SGAP_ASSERT(a_reject_pos, clk, rst_n, reject_beat |-> ((out_place_x == '0) && (out_place_y == '0)))

  // A placed glyph lies inside the atlas height
  `SGAP_ASSERT(a_place_height, clk, rst_n, placed_beat |-> (out_atlas_height > out_place_y))

endmodule

bind skyline_glyph_atlas_packer sgap_checker u_sgap_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_operation     (in_operation),
  .out_strobe       (out_strobe),
  .out_place_x      (out_place_x),
  .out_place_y      (out_place_y),
  .out_atlas_height (out_atlas_height),
  .out_status       (out_status)
);
